>>> src/ssd_pkg.sv
// Shared constants and helper functions for the signed seven-segment digit encoder.
package ssd_pkg;

    localparam int VALUE_W    = 32;
    localparam int COORD_W    = 16;
    localparam int BCD_DIGITS = 10;
    localparam int BITS_PER_STEP = 2;
    localparam int STEPS      = VALUE_W / BITS_PER_STEP;
    localparam int STEP_CNT_W = $clog2(STEPS);

    localparam logic [3:0] SYM_MINUS = 4'd10;
    localparam logic [3:0] SYM_BLANK = 4'd11;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_COUNT    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DOT_POSITION   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_LENGTH = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_WIDTH  = 8'd3;

    localparam logic [4:0] DIGIT_COUNT_RST    = 5'd6;
    localparam logic [4:0] DOT_POSITION_RST   = 5'd0;
    localparam logic [7:0] SEGMENT_LENGTH_RST = 8'd10;
    localparam logic [7:0] SEGMENT_WIDTH_RST  = 8'd3;

    // Double-dabble correction of one BCD digit before it is doubled.
    function automatic logic [3:0] bcd_adjust(input logic [3:0] d);
        logic [3:0] r;
        if (d >= 4'd5) begin
            r = d + 4'd3;
        end else begin
            r = d;
        end
        return r;
    endfunction

    // Segment pattern gfedcba for a digit or a sign symbol.
    function automatic logic [6:0] seg_pattern(input logic [3:0] sym);
        logic [6:0] p;
        case (sym)
            4'd0:      p = 7'h3F;
            4'd1:      p = 7'h06;
            4'd2:      p = 7'h5B;
            4'd3:      p = 7'h4F;
            4'd4:      p = 7'h66;
            4'd5:      p = 7'h6D;
            4'd6:      p = 7'h7D;
            4'd7:      p = 7'h07;
            4'd8:      p = 7'h7F;
            4'd9:      p = 7'h6F;
            SYM_MINUS: p = 7'h40;
            SYM_BLANK: p = 7'h00;
            default:   p = 7'h00;
        endcase
        return p;
    endfunction

endpackage

>>> src/ssd_bcd_cell.sv
// One BCD digit cell of the binary-to-decimal converter chain, two bits per cycle while step is high.
module ssd_bcd_cell
    import ssd_pkg::*;
(
    input  logic       aclk,
    input  logic       clr,
    input  logic       step,
    input  logic       in_hi,
    input  logic       in_lo,
    output logic       carry_hi,
    output logic       carry_lo,
    output logic [3:0] digit,
    output logic [3:0] digit_next
);

    logic [3:0] digit_reg;
    logic [3:0] adj0;
    logic [3:0] half_step;
    logic [3:0] adj1;

    // Two correct-and-shift steps; the bits shifted in come from the lower cell.
    always_comb begin
        adj0       = bcd_adjust(digit_reg);
        half_step  = {adj0[2:0], in_hi};
        adj1       = bcd_adjust(half_step);
        digit_next = {adj1[2:0], in_lo};
    end

    assign carry_hi = adj0[3];
    assign carry_lo = adj1[3];
    assign digit    = digit_reg;

    always_ff @(posedge aclk) begin
        if (clr) begin
            digit_reg <= 4'd0;
        end else if (step) begin
            digit_reg <= digit_next;
        end
    end

endmodule

>>> src/ssd_out_cell.sv
// One symbol cell of the output row, loaded in parallel and shifted toward position zero.
module ssd_out_cell
    import ssd_pkg::*;
(
    input  logic       aclk,
    input  logic       load,
    input  logic       shift,
    input  logic [3:0] load_sym,
    input  logic [3:0] shift_in,
    output logic [3:0] sym
);

    logic [3:0] sym_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            sym_reg <= load_sym;
        end else if (shift) begin
            sym_reg <= shift_in;
        end
    end

    assign sym = (sym_reg > 4'd9) ? 4'd0 : sym_reg;

endmodule

>>> src/signed_seven_segment_digit_encoder.sv
// Top level of the signed seven-segment digit encoder: converter chain, output row, registers.
//
//  Channel  Direction  Handshake              Word
//  s_       in         s_valid / s_ready      value, origin_x, origin_y
//  m_       out        m_valid / m_ready      one digit result, least significant first
//  cfg_     in         cfg_valid / cfg_ready  register index and data
//
// A value is converted in the BCD cell chain, two magnitude bits per cycle. Its n results
// then leave the row at one per cycle while m_ready is high, as the next value converts,
// so a new word is taken before the last one's results have left (n is at most MAX_DIGITS).
// Synchronous reset clears the control state and loads the register defaults; there is no
// clearing pass. A stall on m_ stops the output row; the converter holds a finished value
// until the row frees. s_ready is low from each accepted word until it moves into the row.
module signed_seven_segment_digit_encoder
    import ssd_pkg::*;
#(
    parameter int MAX_DIGITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [31:0]     s_value,
    input  logic signed [15:0]     s_origin_x,
    input  logic signed [15:0]     s_origin_y,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [3:0]             m_position,
    output logic [6:0]             m_segments,
    output logic                   m_dot_lit,
    output logic signed [15:0]     m_digit_x,
    output logic signed [15:0]     m_digit_y,
    output logic                   m_last,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Only the digits that can be shown below the sign position are converted.
    localparam int CELLS = (MAX_DIGITS - 1 < BCD_DIGITS) ? MAX_DIGITS - 1 : BCD_DIGITS;

    // Configuration registers.
    logic [4:0] digit_count_reg;
    logic [4:0] dot_position_reg;
    logic [7:0] segment_length_reg;
    logic [7:0] segment_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digit_count_reg    <= DIGIT_COUNT_RST;
            dot_position_reg   <= DOT_POSITION_RST;
            segment_length_reg <= SEGMENT_LENGTH_RST;
            segment_width_reg  <= SEGMENT_WIDTH_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DIGIT_COUNT:    digit_count_reg    <= cfg_data[4:0];
                REG_DOT_POSITION:   dot_position_reg   <= cfg_data[4:0];
                REG_SEGMENT_LENGTH: segment_length_reg <= cfg_data;
                REG_SEGMENT_WIDTH:  segment_width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Derived geometry.
    logic [3:0]  last_pos;
    logic [9:0]  pitch;
    logic [6:0]  half_width;
    logic [13:0] span;

    always_comb begin
        if (digit_count_reg < 5'd2) begin
            last_pos = 4'd1;
        end else if (digit_count_reg > 5'(MAX_DIGITS)) begin
            last_pos = 4'(MAX_DIGITS - 1);
        end else begin
            last_pos = 4'(digit_count_reg - 5'd1);
        end
    end

    assign pitch      = {2'd0, segment_length_reg} + {1'b0, segment_width_reg, 1'b0};
    assign half_width = segment_width_reg[7:1];
    assign span       = {10'd0, last_pos} * {4'd0, pitch};

    // Converter control.
    logic                  cv_busy_reg;
    logic                  cv_full_reg;
    logic [STEP_CNT_W-1:0] cv_cnt_reg;
    logic [VALUE_W-1:0]    cv_bin_reg;
    logic                  cv_neg_reg;
    logic [COORD_W-1:0]    cv_ox_reg;
    logic [COORD_W-1:0]    cv_oy_reg;

    logic                  cv_step;
    logic                  cv_last;
    logic                  handoff;
    logic                  s_accept;
    logic                  em_free;
    logic                  s_neg;
    logic [VALUE_W-1:0]    s_mag;

    assign cv_step  = cv_busy_reg && !cv_full_reg;
    assign cv_last  = cv_step && (cv_cnt_reg == STEP_CNT_W'(STEPS - 1));
    assign handoff  = (cv_full_reg || cv_last) && em_free;
    assign s_ready  = !cv_busy_reg || handoff;
    assign s_accept = s_valid && s_ready;

    // Negation in 32 bits also gives the right magnitude for the most negative value.
    assign s_neg = s_value[VALUE_W-1];
    assign s_mag = s_neg ? (VALUE_W'(0) - VALUE_W'(s_value)) : VALUE_W'(s_value);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_busy_reg <= 1'b0;
            cv_full_reg <= 1'b0;
            cv_cnt_reg  <= '0;
        end else if (s_accept) begin
            cv_busy_reg <= 1'b1;
            cv_full_reg <= 1'b0;
            cv_cnt_reg  <= '0;
        end else if (handoff) begin
            cv_busy_reg <= 1'b0;
            cv_full_reg <= 1'b0;
        end else if (cv_step) begin
            cv_cnt_reg <= cv_cnt_reg + STEP_CNT_W'(1);
            if (cv_last) begin
                cv_full_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cv_bin_reg <= s_mag;
            cv_neg_reg <= s_neg;
            cv_ox_reg  <= COORD_W'(s_origin_x);
            cv_oy_reg  <= COORD_W'(s_origin_y);
        end else if (cv_step) begin
            cv_bin_reg <= {cv_bin_reg[VALUE_W-3:0], 2'b00};
        end
    end

    // BCD cell chain; magnitude bits enter at the least significant cell, MSB first.
    logic [CELLS:0] chain_hi;
    logic [CELLS:0] chain_lo;
    logic [3:0]     cv_digit      [CELLS];
    logic [3:0]     cv_digit_next [CELLS];

    assign chain_hi[0] = cv_bin_reg[VALUE_W-1];
    assign chain_lo[0] = cv_bin_reg[VALUE_W-2];

    for (genvar i = 0; i < CELLS; i++) begin : g_bcd
        ssd_bcd_cell u_cell (
            .aclk       (aclk),
            .clr        (s_accept),
            .step       (cv_step),
            .in_hi      (chain_hi[i]),
            .in_lo      (chain_lo[i]),
            .carry_hi   (chain_hi[i+1]),
            .carry_lo   (chain_lo[i+1]),
            .digit      (cv_digit[i]),
            .digit_next (cv_digit_next[i])
        );
    end

    // Output row and result registers.
    logic               em_busy_reg;
    logic [3:0]         em_pos_reg;
    logic [3:0]         em_last_pos_reg;
    logic               em_neg_reg;
    logic [COORD_W-1:0] em_x_reg;
    logic [COORD_W-1:0] em_y_reg;

    logic               m_accept;
    logic               em_shift;
    logic               em_at_sign;
    logic [3:0]         em_sym    [CELLS];
    logic [3:0]         em_sym_out;

    assign m_accept   = m_valid && m_ready;
    assign em_at_sign = (em_pos_reg == em_last_pos_reg);
    assign em_free    = !em_busy_reg || (m_accept && em_at_sign);
    assign em_shift   = m_accept && !em_at_sign;

    for (genvar i = 0; i < CELLS; i++) begin : g_out
        logic [3:0] upper_sym;
        if (i == CELLS - 1) begin : g_top
            assign upper_sym = 4'd0;
        end else begin : g_mid
            assign upper_sym = em_sym[i+1];
        end

        ssd_out_cell u_cell (
            .aclk     (aclk),
            .load     (handoff),
            .shift    (em_shift),
            .load_sym (cv_full_reg ? cv_digit[i] : cv_digit_next[i]),
            .shift_in (upper_sym),
            .sym      (em_sym[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            em_busy_reg <= 1'b0;
        end else if (handoff) begin
            em_busy_reg <= 1'b1;
        end else if (m_accept && em_at_sign) begin
            em_busy_reg <= 1'b0;
        end
    end

    // The first result is the rightmost digit; each later one steps one pitch to the left.
    always_ff @(posedge aclk) begin
        if (handoff) begin
            em_pos_reg      <= 4'd0;
            em_last_pos_reg <= last_pos;
            em_neg_reg      <= cv_neg_reg;
            em_x_reg        <= COORD_W'(cv_ox_reg + {2'd0, span} + {9'd0, half_width});
            em_y_reg        <= COORD_W'(cv_oy_reg + {9'd0, half_width});
        end else if (em_shift) begin
            em_pos_reg <= em_pos_reg + 4'd1;
            em_x_reg   <= COORD_W'(em_x_reg - {6'd0, pitch});
        end
    end

    assign em_sym_out = em_at_sign ? (em_neg_reg ? SYM_MINUS : SYM_BLANK) : em_sym[0];

    assign m_valid    = em_busy_reg;
    assign m_position = em_pos_reg;
    assign m_segments = seg_pattern(em_sym_out);
    assign m_dot_lit  = (dot_position_reg == ({1'b0, em_pos_reg} + 5'd1));
    assign m_digit_x  = em_x_reg;
    assign m_digit_y  = em_y_reg;
    assign m_last     = em_at_sign;

endmodule

>>> src/ssd_checker.sv
// Port-level checks on the digit encoder's result stream, bound to the top level.
module ssd_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [3:0]         m_position,
    input  logic [6:0]         m_segments,
    input  logic               m_dot_lit,
    input  logic signed [15:0] m_digit_x,
    input  logic signed [15:0] m_digit_y,
    input  logic               m_last
);

    // A stalled result word holds still.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position) && $stable(m_segments)
            && $stable(m_dot_lit) && $stable(m_digit_x) && $stable(m_digit_y)
            && $stable(m_last))
        else $error("result word changed while stalled");

    // Within one value, the positions follow each other without gaps.
    a_pos_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid && (m_position == $past(m_position) + 4'd1)
            && (m_digit_y == $past(m_digit_y)))
        else $error("position did not advance by one within a value");

    // A new value always starts at the least significant position.
    a_pos_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid || (m_position == 4'd0))
        else $error("value did not start at position zero");

    // The sign position shows only a minus sign or a blank.
    a_sign_sym: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> (m_segments == 7'h40) || (m_segments == 7'h00))
        else $error("sign position shows a digit");

endmodule

bind signed_seven_segment_digit_encoder ssd_checker u_ssd_checker (.*);

>>> tb/signed_seven_segment_digit_encoder_test.sv
// Self-checking testbench for the signed seven-segment digit encoder.
`timescale 1ns / 100ps

module signed_seven_segment_digit_encoder_test;
    import ssd_pkg::*;

    localparam int MAX_DIGITS    = 16;
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [CFG_INDEX_W-1:0] FIRST_UNUSED_INDEX = REG_SEGMENT_WIDTH + 8'd1;

    // Segment patterns gfedcba, symbol 0 in the low seven bits.
    localparam logic [12*7-1:0] GLYPHS = {
        7'h00, 7'h40, 7'h6F, 7'h7F, 7'h07, 7'h7D,
        7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
    };

    typedef struct {
        logic [31:0] value;
        logic [15:0] ox;
        logic [15:0] oy;
        int unsigned gap;
    } display_word_t;

    typedef struct packed {
        logic [3:0]  position;
        logic [6:0]  segments;
        logic        dot_lit;
        logic [15:0] digit_x;
        logic [15:0] digit_y;
        logic        last;
    } digit_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic signed [31:0]     s_value = '0;
    logic signed [15:0]     s_origin_x = '0;
    logic signed [15:0]     s_origin_y = '0;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [3:0]             m_position;
    logic [6:0]             m_segments;
    logic                   m_dot_lit;
    logic signed [15:0]     m_digit_x;
    logic signed [15:0]     m_digit_y;
    logic                   m_last;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Shadow copy of the register file.
    logic [4:0] digit_count_cfg = DIGIT_COUNT_RST;
    logic [4:0] dot_pos_cfg     = DOT_POSITION_RST;
    logic [7:0] seg_len_cfg     = SEGMENT_LENGTH_RST;
    logic [7:0] seg_wid_cfg     = SEGMENT_WIDTH_RST;

    display_word_t pending_words[$];
    display_word_t staged_word;
    digit_word_t   expected_digits[$];

    logic        word_live = 1'b0;
    logic        word_staged = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;
    int unsigned fail_count = 0;

    signed_seven_segment_digit_encoder #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_value(s_value),
        .s_origin_x(s_origin_x),
        .s_origin_y(s_origin_y),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_position(m_position),
        .m_segments(m_segments),
        .m_dot_lit(m_dot_lit),
        .m_digit_x(m_digit_x),
        .m_digit_y(m_digit_y),
        .m_last(m_last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("signed_seven_segment_digit_encoder_test NOT OK");
        $finish;
    end

    function automatic string fmt_digit(input digit_word_t d);
        return $sformatf("pos=%0d seg=%02h dot=%0b x=%04h y=%04h last=%0b",
                         d.position, d.segments, d.dot_lit, d.digit_x, d.digit_y, d.last);
    endfunction

    // Expands one accepted word into its digit results, least significant first.
    function automatic void predict_digits(input logic [31:0] word_value,
                                           input logic [15:0] ox, input logic [15:0] oy);
        logic        negative;
        logic [31:0] magnitude;
        logic [3:0]  sym;
        logic [15:0] pitch;
        logic [15:0] half;
        int          n;
        digit_word_t d;
        negative  = word_value[31];
        magnitude = negative ? (32'd0 - word_value) : word_value;
        n = int'(digit_count_cfg);
        if (n < 2) n = 2;
        if (n > MAX_DIGITS) n = MAX_DIGITS;
        pitch = 16'(seg_len_cfg) + 16'(2 * seg_wid_cfg);
        half  = 16'(seg_wid_cfg >> 1);
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) begin
                sym = negative ? SYM_MINUS : SYM_BLANK;
            end else begin
                sym = 4'(magnitude % 10);
                magnitude = magnitude / 10;
            end
            d.position = 4'(i);
            d.segments = GLYPHS[sym*7 +: 7];
            d.dot_lit  = (dot_pos_cfg != 5'd0) && (int'(dot_pos_cfg) == i + 1);
            d.digit_x  = ox + 16'((n - 1 - i) * pitch) + half;
            d.digit_y  = oy + half;
            d.last     = (i == n - 1);
            expected_digits.push_back(d);
        end
    endfunction

    // Sender: word_live mirrors s_valid, so the payload holds until accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            word_live = 1'b0;
            word_staged = 1'b0;
        end else begin
            if (word_live && s_ready) begin
                predict_digits(s_value, s_origin_x, s_origin_y);
                word_live = 1'b0;
            end
            if (!word_live && !word_staged && pending_words.size() > 0) begin
                staged_word = pending_words.pop_front();
                word_staged = 1'b1;
                gap_left = staged_word.gap;
            end
            if (word_staged) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    s_value <= staged_word.value;
                    s_origin_x <= staged_word.ox;
                    s_origin_y <= staged_word.oy;
                    word_staged = 1'b0;
                    word_live = 1'b1;
                end
            end
            s_valid <= word_live;
        end
    end

    // Receiver: checks each digit word and draws the stall before the next one.
    always @(posedge aclk) begin
        digit_word_t got;
        digit_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_position, m_segments, m_dot_lit, m_digit_x, m_digit_y, m_last};
                if (expected_digits.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected digit word: %s", fmt_digit(got));
                end else begin
                    want = expected_digits.pop_front();
                    if (got.position !== want.position || got.segments !== want.segments ||
                        got.dot_lit !== want.dot_lit || got.digit_x !== want.digit_x ||
                        got.digit_y !== want.digit_y || got.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("digit mismatch at %0t\n  expected %s\n  actual   %s",
                                     $realtime, fmt_digit(want), fmt_digit(got));
                    end
                end
                stall_left = rx_calm ? 0 : $urandom_range(0, 8);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_ready <= (stall_left == 0);
        end
    end

    task automatic queue_word(input logic [31:0] v, input logic [15:0] ox,
                              input logic [15:0] oy);
        display_word_t w;
        w.value = v;
        w.ox = ox;
        w.oy = oy;
        w.gap = tx_calm ? 0 : $urandom_range(0, 8);
        pending_words.push_back(w);
    endtask

    function automatic logic [31:0] rand_value();
        logic [31:0] v;
        int unsigned p;
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 99);
            1: begin
                p = 1;
                repeat ($urandom_range(0, 9)) p = p * 10;
                v = p - $urandom_range(0, 1);
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    default: v = 32'h0;
                endcase
            end
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 1) == 1 && v != 32'h8000_0000) v = 32'd0 - v;
        return v;
    endfunction

    function automatic logic [15:0] rand_coord();
        logic [15:0] c;
        case ($urandom_range(0, 7))
            0: c = 16'h8000;
            1: c = 16'h7FFF;
            2: c = 16'h0000;
            default: c = 16'($urandom);
        endcase
        return c;
    endfunction

    task automatic queue_random_words(input int unsigned count);
        for (int unsigned k = 0; k < count; k++) begin
            if (k % 10 == 0) tx_calm = ($urandom_range(0, 2) == 0);
            queue_word(rand_value(), rand_coord(), rand_coord());
        end
    endtask

    // Holds cfg_valid high across consecutive words; the caller lowers it.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_DIGIT_COUNT:    digit_count_cfg = data[4:0];
            REG_DOT_POSITION:   dot_pos_cfg = data[4:0];
            REG_SEGMENT_LENGTH: seg_len_cfg = data;
            REG_SEGMENT_WIDTH:  seg_wid_cfg = data;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] cnt, input logic [7:0] dot,
                             input logic [7:0] len, input logic [7:0] wid);
        if ($urandom_range(0, 2) == 0)
            write_register(8'($urandom_range(FIRST_UNUSED_INDEX, 255)), 8'($urandom));
        write_register(REG_DIGIT_COUNT, cnt);
        write_register(REG_DOT_POSITION, dot);
        write_register(REG_SEGMENT_LENGTH, len);
        write_register(REG_SEGMENT_WIDTH, wid);
        if ($urandom_range(0, 2) == 0)
            write_register(8'($urandom_range(FIRST_UNUSED_INDEX, 255)), 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Returns once every queued word is accepted and all its digits have come back.
    task automatic drain_results();
        do @(posedge aclk);
        while (pending_words.size() != 0 || word_staged || word_live ||
               expected_digits.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [7:0] cnt;
        logic [7:0] dot;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Register defaults after reset, field extremes and every digit glyph but 2 and 5.
        tx_calm = 1'b0;
        queue_word(32'd0, 16'h0000, 16'h0000);
        queue_word(32'd1, 16'h8000, 16'h8000);
        queue_word(32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF);
        queue_word(32'd9, 16'hFFFF, 16'h0001);
        queue_word(32'd0 - 32'd10, 16'h1234, 16'hFEDC);
        queue_word(32'd1234567890, 16'h0000, 16'h7FFF);
        queue_word(32'd0 - 32'd1234567890, 16'h8000, 16'h0000);
        queue_word(32'h7FFF_FFFF, 16'h0100, 16'h0200);
        queue_word(32'h8000_0000, 16'h0100, 16'h0200);
        queue_word(32'd99999, 16'h0000, 16'h0000);
        queue_word(32'd0 - 32'd100000, 16'h0000, 16'h0000);
        queue_word(32'd567890, 16'hAAAA, 16'h5555);
        drain_results();

        // Register extremes: clamped digit counts, dot off and out of range, wrapping x.
        configure(8'd0, 8'd0, 8'd1, 8'd0);
        queue_word(32'h8000_0000, 16'h0000, 16'h0000);
        queue_random_words(5);
        drain_results();
        configure(8'd1, 8'd1, 8'd255, 8'd255);
        queue_random_words(6);
        drain_results();
        rx_calm = 1'b1;
        configure(8'd16, 8'd16, 8'd255, 8'd0);
        queue_word(32'h8000_0000, 16'h7FFF, 16'h7FFF);
        queue_random_words(5);
        drain_results();
        rx_calm = 1'b0;
        configure(8'd31, 8'd31, 8'd0, 8'd255);
        queue_random_words(6);
        drain_results();
        configure(8'd17, 8'd17, 8'd1, 8'd1);
        queue_random_words(6);
        drain_results();
        configure(8'd255, 8'd2, 8'd128, 8'd127);
        queue_random_words(6);
        drain_results();

        for (int phase = 0; phase < 12; phase++) begin
            case ($urandom_range(0, 3))
                0, 1: cnt = 8'($urandom_range(2, 8));
                default: cnt = 8'($urandom);
            endcase
            if ($urandom_range(0, 3) == 0) dot = 8'($urandom);
            else dot = 8'($urandom_range(0, 9));
            rx_calm = ($urandom_range(0, 3) == 0);
            configure(cnt, dot, 8'($urandom), 8'($urandom));
            queue_random_words(40);
            drain_results();
        end

        if (fail_count == 0 && expected_digits.size() == 0) begin
            $display("signed_seven_segment_digit_encoder_test OK");
        end else begin
            $display("signed_seven_segment_digit_encoder_test NOT OK");
        end
        $finish;
    end

endmodule
